// ===== hdl/mlfr_pkg.sv =====
package mlfr_pkg;

    // channel bank size and wait timer width
    localparam int NUM_CHANNELS = 18;
    localparam int WAIT_BITS    = 16;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // saturation level for an up ramp
    localparam logic [7:0] LEVEL_MAX = 8'hFF;

    // operation codes
    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // ramp direction of one channel
    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_REPORT
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

// ===== hdl/mlfr_ctrl.sv =====
module mlfr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output mlfr_pkg::cmd_t cmd
);

    mlfr_pkg::state_t state_reg;
    mlfr_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlfr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlfr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mlfr_pkg::ST_CALC;
                end
            end
            mlfr_pkg::ST_CALC:
            begin
                state_next = mlfr_pkg::ST_REPORT;
            end
            mlfr_pkg::ST_REPORT:
            begin
                state_next = mlfr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mlfr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy     = 1'b1;
        done     = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        case (state_reg)
            mlfr_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            mlfr_pkg::ST_CALC:
            begin
                cmd.exec = 1'b1;
            end
            mlfr_pkg::ST_REPORT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/mlfr_datapath.sv =====
module mlfr_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  mlfr_pkg::cmd_t cmd,
    input  logic           op,
    input  logic [4:0]     channel,
    input  logic [7:0]     new_target,
    input  logic [7:0]     new_step,
    input  logic [15:0]    new_wait,
    output logic [4:0]     out_channel,
    output logic [7:0]     level,
    output logic [1:0]     direction,
    output logic           stepped
);

    // captured input word
    logic        op_reg;
    logic [4:0]  ch_reg;
    logic [7:0]  tgt_reg;
    logic [7:0]  stp_reg;
    logic [15:0] wait_in_reg;

    // per channel state
    logic [7:0]                    level_reg  [mlfr_pkg::NUM_CHANNELS];
    logic [7:0]                    target_reg [mlfr_pkg::NUM_CHANNELS];
    logic [7:0]                    step_reg   [mlfr_pkg::NUM_CHANNELS];
    mlfr_pkg::dir_t                dir_reg    [mlfr_pkg::NUM_CHANNELS];
    logic [mlfr_pkg::WAIT_BITS-1:0] wait_reg  [mlfr_pkg::NUM_CHANNELS];

    // result word
    logic [4:0] out_channel_reg;
    logic [7:0] level_out_reg;
    logic [1:0] direction_reg;
    logic       stepped_reg;

    logic [mlfr_pkg::CH_IDX_W-1:0]  idx;
    logic                           ch_ok;
    logic [7:0]                     cur_lv;
    logic [7:0]                     cur_tgt;
    logic [7:0]                     cur_stp;
    mlfr_pkg::dir_t                 cur_dir;
    logic [mlfr_pkg::WAIT_BITS-1:0] cur_wait;
    logic [7:0]                     eff_tgt;
    logic [7:0]                     eff_stp;
    mlfr_pkg::dir_t                 eff_dir;
    logic [8:0]                     sum;
    logic [7:0]                     new_lv;
    mlfr_pkg::dir_t                 new_dir;
    logic                           do_step;
    logic                           do_tick;
    logic [7:0]                     level_next;
    logic [1:0]                     direction_next;

    // capture the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op;
            ch_reg      <= channel;
            tgt_reg     <= new_target;
            stp_reg     <= new_step;
            wait_in_reg <= new_wait;
        end
    end

    // read the addressed channel
    always_comb
    begin
        idx      = mlfr_pkg::CH_IDX_W'(ch_reg);
        ch_ok    = (32'(ch_reg) < mlfr_pkg::NUM_CHANNELS);
        cur_lv   = level_reg[idx];
        cur_tgt  = target_reg[idx];
        cur_stp  = step_reg[idx];
        cur_dir  = dir_reg[idx];
        cur_wait = wait_reg[idx];
    end

    // latch a new ramp when idle and pick its direction
    always_comb
    begin
        if (cur_dir == mlfr_pkg::DIR_IDLE)
        begin
            eff_tgt = tgt_reg;
            eff_stp = stp_reg;
            eff_dir = (tgt_reg > cur_lv) ? mlfr_pkg::DIR_UP : mlfr_pkg::DIR_DOWN;
        end
        else
        begin
            eff_tgt = cur_tgt;
            eff_stp = cur_stp;
            eff_dir = cur_dir;
        end
    end

    // one step with saturation, back to idle at or past the target
    always_comb
    begin
        sum     = {1'b0, cur_lv} + {1'b0, eff_stp};
        new_lv  = cur_lv;
        new_dir = eff_dir;
        case (eff_dir)
            mlfr_pkg::DIR_UP:
            begin
                new_lv  = sum[8] ? mlfr_pkg::LEVEL_MAX : sum[7:0];
                new_dir = (new_lv >= eff_tgt) ? mlfr_pkg::DIR_IDLE : mlfr_pkg::DIR_UP;
            end
            mlfr_pkg::DIR_DOWN:
            begin
                new_lv  = (cur_lv > eff_stp) ? (cur_lv - eff_stp) : 8'd0;
                new_dir = (new_lv <= eff_tgt) ? mlfr_pkg::DIR_IDLE : mlfr_pkg::DIR_DOWN;
            end
            default:
            begin
                new_lv  = cur_lv;
                new_dir = eff_dir;
            end
        endcase
    end

    // step only when the timer of a valid channel has run out
    always_comb
    begin
        do_tick = cmd.exec && (op_reg == mlfr_pkg::OP_TICK);
        do_step = cmd.exec && (op_reg == mlfr_pkg::OP_PROCESS) && ch_ok
                  && (cur_wait == '0);
        if (!ch_ok)
        begin
            level_next     = 8'd0;
            direction_next = mlfr_pkg::DIR_IDLE;
        end
        else if (do_step)
        begin
            level_next     = new_lv;
            direction_next = new_dir;
        end
        else
        begin
            level_next     = cur_lv;
            direction_next = cur_dir;
        end
    end

    // channel state update and timer tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mlfr_pkg::NUM_CHANNELS; i++)
            begin
                level_reg[i]  <= 8'd0;
                target_reg[i] <= 8'd0;
                step_reg[i]   <= 8'd1;
                dir_reg[i]    <= mlfr_pkg::DIR_IDLE;
                wait_reg[i]   <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < mlfr_pkg::NUM_CHANNELS; i++)
            begin
                if (do_tick && (wait_reg[i] != '0))
                begin
                    wait_reg[i] <= wait_reg[i] - 1'b1;
                end
                if (do_step && (idx == mlfr_pkg::CH_IDX_W'(i)))
                begin
                    level_reg[i]  <= new_lv;
                    target_reg[i] <= eff_tgt;
                    step_reg[i]   <= eff_stp;
                    dir_reg[i]    <= new_dir;
                    wait_reg[i]   <= mlfr_pkg::WAIT_BITS'(wait_in_reg);
                end
            end
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_channel_reg <= ch_reg;
            level_out_reg   <= level_next;
            direction_reg   <= direction_next;
            stepped_reg     <= do_step;
        end
    end

    assign out_channel = out_channel_reg;
    assign level       = level_out_reg;
    assign direction   = direction_reg;
    assign stepped     = stepped_reg;

endmodule

// ===== hdl/multichannel_led_fade_ramp.sv =====
// Bank of LED fade ramps, one per channel. A word is taken when start is high
// and busy is low; op 0 steps the addressed channel if its wait timer is zero,
// op 1 decrements every nonzero wait timer. From acceptance, a word is first
// captured, then the channel entry is read, updated and written back while the
// result word is registered, and then the result is presented. The result word
// sits on out_channel, level, direction and stepped for exactly one cycle with
// done high, and the receiver cannot stall it. busy is low again in the cycle
// after done, so a new word is accepted only once the previous one is through,
// as paced by the controller sequence.
module multichannel_led_fade_ramp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        op,
    input  logic [4:0]  channel,
    input  logic [7:0]  new_target,
    input  logic [7:0]  new_step,
    input  logic [15:0] new_wait,
    output logic [4:0]  out_channel,
    output logic [7:0]  level,
    output logic [1:0]  direction,
    output logic        stepped
);

    mlfr_pkg::cmd_t cmd;

    // sequencer
    mlfr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // channel state and ramp arithmetic
    mlfr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op          (op),
        .channel     (channel),
        .new_target  (new_target),
        .new_step    (new_step),
        .new_wait    (new_wait),
        .out_channel (out_channel),
        .level       (level),
        .direction   (direction),
        .stepped     (stepped)
    );

endmodule

// ===== hdl/mlfr_checker.sv =====
module mlfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [4:0]  out_channel,
    input logic [7:0]  level,
    input logic [1:0]  direction,
    input logic        stepped
);

    // an accepted word raises busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // a result word with done follows every accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result word missing after accept");

    // the done strobe lasts a single cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // direction is always one of the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((direction == mlfr_pkg::DIR_IDLE) || (direction == mlfr_pkg::DIR_UP)
                  || (direction == mlfr_pkg::DIR_DOWN)))
        else $error("illegal direction code");

    // an out of range channel reports an empty word
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (32'(out_channel) >= mlfr_pkg::NUM_CHANNELS))
            |-> ((level == 8'd0) && (direction == mlfr_pkg::DIR_IDLE) && !stepped))
        else $error("out of range channel reported state");

endmodule

bind multichannel_led_fade_ramp mlfr_checker u_mlfr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .out_channel (out_channel),
    .level       (level),
    .direction   (direction),
    .stepped     (stepped)
);

// ===== dv/fade_ramp_checker.sv =====
module fade_ramp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        done,
    input  logic        op,
    input  logic [4:0]  channel,
    input  logic [7:0]  new_target,
    input  logic [7:0]  new_step,
    input  logic [15:0] new_wait,
    input  logic [4:0]  out_channel,
    input  logic [7:0]  level,
    input  logic [1:0]  direction,
    input  logic        stepped,
    output int          fail_count,
    output int          pending,
    output int          results_checked,
    output int          steps_seen,
    output int          ticks_seen
);

    // one result word as the block should report it
    typedef struct packed {
        logic [4:0] chan;
        logic [7:0] lvl;
        logic [1:0] dir;
        logic       moved;
    } fade_word_t;

    // private copy of the fader bank
    logic [7:0]                     lvl_mem  [mlfr_pkg::NUM_CHANNELS];
    logic [7:0]                     tgt_mem  [mlfr_pkg::NUM_CHANNELS];
    logic [7:0]                     rate_mem [mlfr_pkg::NUM_CHANNELS];
    mlfr_pkg::dir_t                 dir_mem  [mlfr_pkg::NUM_CHANNELS];
    logic [mlfr_pkg::WAIT_BITS-1:0] wait_mem [mlfr_pkg::NUM_CHANNELS];

    fade_word_t level_reports [$];
    int         mismatches = 0;
    int         checked    = 0;
    int         steps      = 0;
    int         ticks      = 0;

    // apply one word to the bank and return the report it should produce
    function automatic fade_word_t advance_fader(input logic o, input logic [4:0] ch,
                                                 input logic [7:0] tgt, input logic [7:0] rate,
                                                 input logic [15:0] wt);
        fade_word_t   res;
        int unsigned  lv;
        logic         moved;
        moved = 1'b0;
        if (o == mlfr_pkg::OP_TICK)
        begin
            ticks++;
            for (int i = 0; i < mlfr_pkg::NUM_CHANNELS; i++)
                if (wait_mem[i] != '0)
                    wait_mem[i] = wait_mem[i] - 1'b1;
        end
        else if (ch < mlfr_pkg::NUM_CHANNELS && wait_mem[ch] == '0)
        begin
            moved = 1'b1;
            steps++;
            // an idle fader latches a fresh ramp, equal level counts as down
            if (dir_mem[ch] == mlfr_pkg::DIR_IDLE)
            begin
                tgt_mem[ch]  = tgt;
                rate_mem[ch] = rate;
                dir_mem[ch]  = (tgt > lvl_mem[ch]) ? mlfr_pkg::DIR_UP : mlfr_pkg::DIR_DOWN;
            end
            lv = lvl_mem[ch];
            if (dir_mem[ch] == mlfr_pkg::DIR_UP)
            begin
                lv = lv + rate_mem[ch];
                if (lv > mlfr_pkg::LEVEL_MAX)
                    lv = mlfr_pkg::LEVEL_MAX;
                if (lv >= tgt_mem[ch])
                    dir_mem[ch] = mlfr_pkg::DIR_IDLE;
            end
            else if (dir_mem[ch] == mlfr_pkg::DIR_DOWN)
            begin
                lv = (lv > rate_mem[ch]) ? lv - rate_mem[ch] : 0;
                if (lv <= tgt_mem[ch])
                    dir_mem[ch] = mlfr_pkg::DIR_IDLE;
            end
            lvl_mem[ch]  = lv[7:0];
            wait_mem[ch] = mlfr_pkg::WAIT_BITS'(wt);
        end
        res.chan  = ch;
        res.lvl   = (ch < mlfr_pkg::NUM_CHANNELS) ? lvl_mem[ch] : 8'd0;
        res.dir   = (ch < mlfr_pkg::NUM_CHANNELS) ? dir_mem[ch] : mlfr_pkg::DIR_IDLE;
        res.moved = moved;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fade_word_t want;
        if (!rst_n)
        begin
            // bank comes out of reset idle with unit steps
            for (int i = 0; i < mlfr_pkg::NUM_CHANNELS; i++)
            begin
                lvl_mem[i]  = '0;
                tgt_mem[i]  = '0;
                rate_mem[i] = 8'd1;
                dir_mem[i]  = mlfr_pkg::DIR_IDLE;
                wait_mem[i] = '0;
            end
            level_reports.delete();
            pending <= 0;
        end
        else
        begin
            // compare a result word against the oldest prediction
            if ($isunknown(done))
            begin
                mismatches++;
                $error("done is unknown");
            end
            else if (done)
            begin
                checked++;
                if (level_reports.size() == 0)
                begin
                    mismatches++;
                    $error("result word for channel %0d with nothing expected", out_channel);
                end
                else
                begin
                    want = level_reports.pop_front();
                    if (out_channel !== want.chan)
                    begin
                        mismatches++;
                        $error("out_channel: expected %0d, got %0d", want.chan, out_channel);
                    end
                    if (level !== want.lvl)
                    begin
                        mismatches++;
                        $error("level: expected %0d, got %0d", want.lvl, level);
                    end
                    if (direction !== want.dir)
                    begin
                        mismatches++;
                        $error("direction: expected %0d, got %0d", want.dir, direction);
                    end
                    if (stepped !== want.moved)
                    begin
                        mismatches++;
                        $error("stepped: expected %0d, got %0d", want.moved, stepped);
                    end
                end
            end
            // predict the word taken at this edge
            if (start && !busy)
                level_reports.push_back(advance_fader(op, channel, new_target, new_step,
                                                      new_wait));
            pending <= level_reports.size();
        end
        fail_count      <= mismatches;
        results_checked <= checked;
        steps_seen      <= steps;
        ticks_seen      <= ticks;
    end

endmodule

// ===== dv/multichannel_led_fade_ramp_tb.sv =====
module multichannel_led_fade_ramp_tb;

    localparam int          RANDOM_WORDS = 1900;
    localparam int          IDLE_LIMIT   = 500;
    // one fader is left to lock on a zero step, one is parked on a long wait
    localparam logic [4:0]  STALL_CH     = 5'(mlfr_pkg::NUM_CHANNELS - 2);
    localparam logic [4:0]  PARKED_CH    = 5'(mlfr_pkg::NUM_CHANNELS - 1);

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic        op         = mlfr_pkg::OP_PROCESS;
    logic [4:0]  channel    = '0;
    logic [7:0]  new_target = '0;
    logic [7:0]  new_step   = '0;
    logic [15:0] new_wait   = '0;
    logic        busy;
    logic        done;
    logic [4:0]  out_channel;
    logic [7:0]  level;
    logic [1:0]  direction;
    logic        stepped;

    int fail_count;
    int pending;
    int results_checked;
    int steps_seen;
    int ticks_seen;
    int words_sent  = 0;
    int idle_cycles = 0;

    always #10 clk = ~clk;

    multichannel_led_fade_ramp u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .done        (done),
        .op          (op),
        .channel     (channel),
        .new_target  (new_target),
        .new_step    (new_step),
        .new_wait    (new_wait),
        .out_channel (out_channel),
        .level       (level),
        .direction   (direction),
        .stepped     (stepped)
    );

    fade_ramp_checker u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .done            (done),
        .op              (op),
        .channel         (channel),
        .new_target      (new_target),
        .new_step        (new_step),
        .new_wait        (new_wait),
        .out_channel     (out_channel),
        .level           (level),
        .direction       (direction),
        .stepped         (stepped),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .steps_seen      (steps_seen),
        .ticks_seen      (ticks_seen)
    );

    // watchdog on cycles with no word taken and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // present one word and hold it until the block takes it
    task automatic send_word(input logic o, input logic [4:0] ch, input logic [7:0] tgt,
                             input logic [7:0] rate, input logic [15:0] wt);
        start      <= 1'b1;
        op         <= o;
        channel    <= ch;
        new_target <= tgt;
        new_step   <= rate;
        new_wait   <= wt;
        @(posedge clk);
        while (!(start && !busy))
            @(posedge clk);
        words_sent++;
    endtask

    // gap between bursts
    task automatic hold_off(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // mostly ramps on live faders, the rest ticks and noise
    task automatic random_word();
        int unsigned pick;
        logic [7:0]  tgt;
        logic [7:0]  rate;
        logic [15:0] wt;
        pick = $urandom_range(0, 99);
        if (pick < 22)
        begin
            send_word(mlfr_pkg::OP_TICK, 5'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom));
        end
        else if (pick < 30)
        begin
            send_word(mlfr_pkg::OP_PROCESS, 5'($urandom_range(mlfr_pkg::NUM_CHANNELS, 31)),
                      8'($urandom), 8'($urandom), 16'($urandom));
        end
        else if (pick < 33)
        begin
            send_word(mlfr_pkg::OP_PROCESS, PARKED_CH, 8'($urandom), 8'($urandom),
                      16'($urandom));
        end
        else if (pick < 35)
        begin
            send_word(mlfr_pkg::OP_PROCESS, STALL_CH, 8'($urandom),
                      ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom), 16'd0);
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:       tgt = 8'd0;
                1:       tgt = mlfr_pkg::LEVEL_MAX;
                default: tgt = 8'($urandom);
            endcase
            rate = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                               : 8'($urandom_range(1, 40));
            pick = $urandom_range(0, 19);
            if (pick < 12)
                wt = 16'd0;
            else if (pick < 19)
                wt = 16'($urandom_range(1, 3));
            else
                wt = 16'($urandom_range(4, 12));
            send_word(mlfr_pkg::OP_PROCESS, 5'($urandom_range(0, mlfr_pkg::NUM_CHANNELS - 3)),
                      tgt, rate, wt);
        end
    endtask

    initial
    begin
        int n_left;
        int burst;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale up ramp saturates, equal target steps down, then floor
        send_word(mlfr_pkg::OP_PROCESS, 5'd0, 8'd255, 8'd255, 16'd0);
        send_word(mlfr_pkg::OP_PROCESS, 5'd0, 8'd255, 8'd1, 16'd0);
        send_word(mlfr_pkg::OP_PROCESS, 5'd0, 8'd0, 8'd255, 16'd0);
        // multi-step ramp held off by its wait timer
        send_word(mlfr_pkg::OP_PROCESS, 5'd1, 8'd200, 8'd50, 16'd2);
        send_word(mlfr_pkg::OP_PROCESS, 5'd1, 8'd10, 8'd3, 16'd0);
        send_word(mlfr_pkg::OP_TICK, 5'd1, 8'd0, 8'd0, 16'd0);
        send_word(mlfr_pkg::OP_PROCESS, 5'd1, 8'd10, 8'd3, 16'd0);
        send_word(mlfr_pkg::OP_TICK, 5'd31, 8'd255, 8'd255, 16'hFFFF);
        hold_off(3);
        send_word(mlfr_pkg::OP_PROCESS, 5'd1, 8'd10, 8'd3, 16'd0);
        send_word(mlfr_pkg::OP_PROCESS, 5'd1, 8'd0, 8'd0, 16'd0);
        send_word(mlfr_pkg::OP_PROCESS, 5'd1, 8'd0, 8'd0, 16'd0);
        // out-of-range channels leave the bank alone
        send_word(mlfr_pkg::OP_PROCESS, 5'(mlfr_pkg::NUM_CHANNELS), 8'd77, 8'd9, 16'd0);
        send_word(mlfr_pkg::OP_PROCESS, 5'd31, 8'd255, 8'd255, 16'hFFFF);
        send_word(mlfr_pkg::OP_TICK, 5'd0, 8'd255, 8'd255, 16'hFFFF);
        // zero step locks an up ramp
        send_word(mlfr_pkg::OP_PROCESS, STALL_CH, 8'd100, 8'd0, 16'd0);
        send_word(mlfr_pkg::OP_PROCESS, STALL_CH, 8'd5, 8'd9, 16'd0);
        // zero step at equal level just returns to idle
        send_word(mlfr_pkg::OP_PROCESS, PARKED_CH, 8'd0, 8'd0, 16'd0);
        // longest wait parks the fader for the rest of the run
        send_word(mlfr_pkg::OP_PROCESS, PARKED_CH, 8'd128, 8'd7, 16'hFFFF);
        send_word(mlfr_pkg::OP_TICK, PARKED_CH, 8'd0, 8'd0, 16'd0);
        send_word(mlfr_pkg::OP_PROCESS, PARKED_CH, 8'd128, 8'd7, 16'd0);
        send_word(mlfr_pkg::OP_PROCESS, 5'd2, 8'd0, 8'd0, 16'h5555);
        send_word(mlfr_pkg::OP_PROCESS, 5'd3, 8'd170, 8'd170, 16'hAAAA);
        hold_off(2);

        // random bursts, now and then a long one with no gaps
        n_left = RANDOM_WORDS;
        while (n_left > 0)
        begin
            burst = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
            for (int k = 0; k < burst && n_left > 0; k++)
            begin
                random_word();
                n_left--;
            end
            hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
        hold_off(1);

        // drain and let the block settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d words driven, %0d of them timer ticks; %0d results checked",
                 words_sent, ticks_seen, results_checked);
        $display("%0d fader steps taken across %0d channels", steps_seen,
                 mlfr_pkg::NUM_CHANNELS);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
